[hw/rtl/pdw_pkg.sv]
// Package for the periodic displacement wrap: widths, register indexes, helpers.
package pdw_pkg;

  localparam int DimCount   = 3;
  localparam int CompW      = 21;
  localparam int VecW       = 3 * CompW;
  localparam int DeltaW     = 32;
  localparam int ProdW      = CompW + DeltaW;
  localparam int SumW       = ProdW + 2;
  localparam int FracShift  = 36;
  localparam int CountW     = SumW - FracShift;
  localparam int StepW      = CountW + CompW;
  localparam int ScaleShift = 8;
  localparam int DiffW      = StepW + ScaleShift + 1;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = VecW;
  localparam int DimsW      = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACTIVE_DIMS = 3'd0,
    REG_CELL_A      = 3'd1,
    REG_CELL_B      = 3'd2,
    REG_CELL_C      = 3'd3,
    REG_RECIP_A     = 3'd4,
    REG_RECIP_B     = 3'd5,
    REG_RECIP_C     = 3'd6,
    REG_UNUSED      = 3'd7
  } cfg_reg_t;

  localparam logic signed [SumW-1:0] HalfCoord = SumW'(1) <<< (FracShift - 1);

  typedef logic signed [DeltaW-1:0] delta_t;

  // Clamp an exact difference to the signed 32-bit range.
  function automatic delta_t sat_delta(input logic signed [DiffW-1:0] v);
    logic signed [DiffW-1:0] hi;
    logic signed [DiffW-1:0] lo;
    hi = DiffW'($signed({1'b0, {(DeltaW-1){1'b1}}}));
    lo = DiffW'($signed({1'b1, {(DeltaW-1){1'b0}}}));
    if (v > hi) begin
      sat_delta = hi[DeltaW-1:0];
    end else if (v < lo) begin
      sat_delta = lo[DeltaW-1:0];
    end else begin
      sat_delta = v[DeltaW-1:0];
    end
  endfunction

endpackage

[hw/rtl/pdw_if.sv]
// Stream interfaces for displacement requests and wrapped results.
interface pdw_in_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic signed [pdw_pkg::DeltaW-1:0] delta_x;
  logic signed [pdw_pkg::DeltaW-1:0] delta_y;
  logic signed [pdw_pkg::DeltaW-1:0] delta_z;

  modport source (output valid, req_type, delta_x, delta_y, delta_z, input ready);
  modport sink   (input valid, req_type, delta_x, delta_y, delta_z, output ready);
endinterface

interface pdw_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [pdw_pkg::DeltaW-1:0] wrapped_x;
  logic signed [pdw_pkg::DeltaW-1:0] wrapped_y;
  logic signed [pdw_pkg::DeltaW-1:0] wrapped_z;

  modport source (output valid, wrapped_x, wrapped_y, wrapped_z, input ready);
  modport sink   (input valid, wrapped_x, wrapped_y, wrapped_z, output ready);
endinterface

[hw/rtl/periodic_displacement_wrap_top.sv]
// Top level: pipelined minimum-image / box wrap of a displacement in a triclinic cell.
//
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+------------------------------------------
//  in_ch     | in  | valid/ready  | req_type, delta_x/y/z (Q15.16)
//  out_ch    | out | valid/ready  | wrapped_x/y/z (Q15.16, saturated)
//  cfg_*     | in  | write enable | cfg_idx selects register, cfg_data value
//
// One request per cycle sustained while out_ch is ready; the pipeline runs through three cell vectors,
// four stages each (dot-product multiplies, sum and round, step multiply,
// subtract and saturate). Inactive vectors still take their four stages.
// rst_n is synchronous, clears valid bits and the cell and reciprocal registers, and sets active dims to 3.
// Each stage holds its data while the next stage is full and stalled, so a
// stall at out_ch fills the bubbles before in_ch deasserts ready.
module periodic_displacement_wrap_top (
  input  logic                            clk,
  input  logic                            rst_n,
  pdw_in_if.sink                          in_ch,
  pdw_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [pdw_pkg::CfgIdxW-1:0]     cfg_idx,
  input  logic [pdw_pkg::CfgDataW-1:0]    cfg_data
);

  localparam int N  = pdw_pkg::DimCount;
  localparam int CW = pdw_pkg::CompW;

  // ---------------- configuration registers ----------------
  logic [pdw_pkg::DimsW-1:0] active_dims_r;
  logic [pdw_pkg::VecW-1:0]  cell_r  [N];
  logic [pdw_pkg::VecW-1:0]  recip_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_dims_r <= pdw_pkg::DimsW'(3);
      for (int i = 0; i < N; i++) begin
        cell_r[i]  <= '0;
        recip_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (pdw_pkg::cfg_reg_t'(cfg_idx))
        pdw_pkg::REG_ACTIVE_DIMS: active_dims_r <= cfg_data[pdw_pkg::DimsW-1:0];
        pdw_pkg::REG_CELL_A:      cell_r[0]  <= cfg_data;
        pdw_pkg::REG_CELL_B:      cell_r[1]  <= cfg_data;
        pdw_pkg::REG_CELL_C:      cell_r[2]  <= cfg_data;
        pdw_pkg::REG_RECIP_A:     recip_r[0] <= cfg_data;
        pdw_pkg::REG_RECIP_B:     recip_r[1] <= cfg_data;
        pdw_pkg::REG_RECIP_C:     recip_r[2] <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------- pipeline boundaries between vectors ----------------
  // Boundary k feeds vector k; boundary N is the output register.
  logic                 bv    [N+1];
  logic                 bbox  [N+1];
  pdw_pkg::delta_t      bd    [N+1][3];
  logic                 brdy  [N+1];

  assign bv[0]    = in_ch.valid;
  assign bbox[0]  = in_ch.req_type;
  assign bd[0][0] = in_ch.delta_x;
  assign bd[0][1] = in_ch.delta_y;
  assign bd[0][2] = in_ch.delta_z;
  assign in_ch.ready = brdy[0];

  assign brdy[N]          = out_ch.ready;
  assign out_ch.valid     = bv[N];
  assign out_ch.wrapped_x = bd[N][0];
  assign out_ch.wrapped_y = bd[N][1];
  assign out_ch.wrapped_z = bd[N][2];

  for (genvar k = 0; k < N; k++) begin : g_dim
    // stage 1: three recip * delta products
    logic                                 v1_r, box1_r;
    pdw_pkg::delta_t                      d1_r [3];
    logic signed [pdw_pkg::ProdW-1:0]     p1_r [3];
    // stage 2: cell count, rounded (minimum image) or floored (box)
    logic                                 v2_r, box2_r;
    pdw_pkg::delta_t                      d2_r [3];
    logic signed [pdw_pkg::CountW-1:0]    n2_r;
    // stage 3: count * cell component
    logic                                 v3_r;
    logic                                 box3_r;
    pdw_pkg::delta_t                      d3_r [3];
    logic signed [pdw_pkg::StepW-1:0]     s3_r [3];
    // stage 4: subtract and clamp, lands on boundary k+1
    logic                                 v4_r, box4_r;
    pdw_pkg::delta_t                      d4_r [3];

    logic e1, e2, e3, e4;
    logic active;
    logic signed [pdw_pkg::SumW-1:0]      sum_nxt;
    pdw_pkg::delta_t                      d4_nxt [3];

    assign e4 = !v4_r || brdy[k+1];
    assign e3 = !v3_r || e4;
    assign e2 = !v2_r || e3;
    assign e1 = !v1_r || e2;
    assign brdy[k] = e1;

    assign active = (pdw_pkg::DimsW'(k) < active_dims_r);

    always_comb begin
      sum_nxt = pdw_pkg::SumW'(p1_r[0]) + pdw_pkg::SumW'(p1_r[1])
              + pdw_pkg::SumW'(p1_r[2]);
      if (!box1_r) begin
        sum_nxt = sum_nxt + pdw_pkg::HalfCoord;
      end
    end

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        if (active) begin
          d4_nxt[j] = pdw_pkg::sat_delta(
              pdw_pkg::DiffW'(d3_r[j])
            - pdw_pkg::DiffW'($signed({s3_r[j], {pdw_pkg::ScaleShift{1'b0}}})));
        end else begin
          d4_nxt[j] = d3_r[j];
        end
      end
    end

    // valid bits
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v1_r <= 1'b0;
        v2_r <= 1'b0;
        v3_r <= 1'b0;
        v4_r <= 1'b0;
      end else begin
        if (e1) v1_r <= bv[k];
        if (e2) v2_r <= v1_r;
        if (e3) v3_r <= v2_r;
        if (e4) v4_r <= v3_r;
      end
    end

    // payload
    always_ff @(posedge clk) begin
      if (e1) begin
        box1_r <= bbox[k];
        for (int j = 0; j < 3; j++) begin
          d1_r[j] <= bd[k][j];
          p1_r[j] <= pdw_pkg::ProdW'($signed(recip_r[k][CW*j +: CW]))
                   * pdw_pkg::ProdW'(bd[k][j]);
        end
      end
      if (e2) begin
        box2_r <= box1_r;
        d2_r   <= d1_r;
        n2_r   <= sum_nxt[pdw_pkg::SumW-1:pdw_pkg::FracShift];  // floor by shift
      end
      if (e3) begin
        box3_r <= box2_r;
        d3_r   <= d2_r;
        for (int j = 0; j < 3; j++) begin
          s3_r[j] <= pdw_pkg::StepW'(n2_r)
                   * pdw_pkg::StepW'($signed(cell_r[k][CW*j +: CW]));
        end
      end
      if (e4) begin
        box4_r <= box3_r;
        d4_r   <= d4_nxt;
      end
    end

    assign bv[k+1]   = v4_r;
    assign bbox[k+1] = box4_r;
    assign bd[k+1]   = d4_r;
  end

endmodule

[tb/pdw_wrap_checker.sv]
// Checker for the displacement wrap: mirrors the registers, predicts each result, compares.
`timescale 1ns / 1ps
module pdw_wrap_checker
  import pdw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  pdw_in_if                   in_ch,
  pdw_out_if                  out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  fail_count,
  output int                  pending
);

  // index 0 is x, 2 is z
  typedef logic [DimCount-1:0][DeltaW-1:0] disp_t;

  localparam longint RoundHalf = longint'(1) <<< (FracShift - 1);
  localparam longint DeltaMax  = 64'sd2147483647;
  localparam longint DeltaMin  = -64'sd2147483648;

  logic [DimsW-1:0] dims_q;
  logic [VecW-1:0]  cell_q  [DimCount];
  logic [VecW-1:0]  recip_q [DimCount];
  disp_t            wrapped_q [$];
  disp_t            got;
  disp_t            want;
  string            field_name [DimCount] = '{"wrapped_x", "wrapped_y", "wrapped_z"};

  assign pending = wrapped_q.size();

  function automatic longint comp21(input logic [VecW-1:0] vec, input int slot);
    logic signed [CompW-1:0] c;
    c = vec[slot*CompW +: CompW];
    return longint'(c);
  endfunction

  // Walk the active lattice vectors a, b, c; each stage saturates to 32 bits.
  function automatic disp_t wrap_displacement(input logic box_mode, input disp_t delta);
    longint d [DimCount];
    longint dot;
    longint n;
    longint v;
    disp_t  res;
    for (int j = 0; j < DimCount; j++) d[j] = longint'($signed(delta[j]));
    for (int k = 0; k < DimCount; k++) begin
      if (k < int'(dims_q)) begin
        dot = 0;
        for (int j = 0; j < DimCount; j++) dot += comp21(recip_q[k], j) * d[j];
        if (!box_mode) dot += RoundHalf;
        n = dot >>> FracShift;
        for (int j = 0; j < DimCount; j++) begin
          v = d[j] - ((n * comp21(cell_q[k], j)) <<< ScaleShift);
          d[j] = (v > DeltaMax) ? DeltaMax : ((v < DeltaMin) ? DeltaMin : v);
        end
      end
    end
    for (int j = 0; j < DimCount; j++) res[j] = DeltaW'(d[j]);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      dims_q = 2'd3;
      for (int i = 0; i < DimCount; i++) begin
        cell_q[i]  = '0;
        recip_q[i] = '0;
      end
      wrapped_q.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.wrapped_z, out_ch.wrapped_y, out_ch.wrapped_x};
        if (wrapped_q.size() == 0) begin
          $error("result with no request pending: x=%0d y=%0d z=%0d",
                 $signed(got[0]), $signed(got[1]), $signed(got[2]));
          fail_count++;
        end else begin
          want = wrapped_q.pop_front();
          for (int j = 0; j < DimCount; j++) begin
            if (got[j] !== want[j]) begin
              $error("%s mismatch: expected %0d, got %0d",
                     field_name[j], $signed(want[j]), $signed(got[j]));
              fail_count++;
            end
          end
        end
      end
      // registers must change only while idle, which the bench keeps to and nothing here checks; old values apply here
      if (in_ch.valid && in_ch.ready) begin
        wrapped_q = {wrapped_q, wrap_displacement(in_ch.req_type,
                                {in_ch.delta_z, in_ch.delta_y, in_ch.delta_x})};
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_ACTIVE_DIMS: dims_q = cfg_data[DimsW-1:0];
          REG_CELL_A, REG_CELL_B, REG_CELL_C: cell_q[cfg_idx - REG_CELL_A] = cfg_data;
          REG_RECIP_A, REG_RECIP_B, REG_RECIP_C: recip_q[cfg_idx - REG_RECIP_A] = cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

[tb/tb.sv]
// Testbench top: drives requests, register writes and result back-pressure, gives the verdict.
`timescale 1ns / 1ps
module tb;
  import pdw_pkg::*;

  typedef enum logic {
    WRAP_MIN_IMAGE = 1'b0,
    WRAP_BOX       = 1'b1
  } wrap_mode_t;

  // Q15.16 displacement corner values
  localparam delta_t PosFour  = 32'sh0004_0000;
  localparam delta_t NegFour  = -32'sh0004_0000;
  localparam delta_t NegHalf  = -32'sh0000_8000;
  localparam delta_t Hundred  = 32'sh0064_0000;
  localparam delta_t DeltaMax = 32'sh7FFF_FFFF;
  localparam delta_t DeltaMin = 32'sh8000_0000;

  // An 8.0 cube: cell side in Q12.8 and its exact reciprocal 0.125 in Q0.20.
  // With these, a 4.0 offset lands the fractional coordinate exactly on one half.
  localparam int CellEight   = 8 * 256;
  localparam int RecipEighth = 1 << 17;

  localparam int  CompMax    = (1 << (CompW - 1)) - 1;
  localparam int  CompMin    = -(1 << (CompW - 1));
  localparam real RecipScale = 1048576.0;
  localparam int unsigned FullSpan = 32'h3FFF_FFFF;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int                  fail_count;
  int                  pending;

  // Random gaps on both channels; cleared for the last phase.
  bit                  idling = 1'b1;
  // Half-width (Q15.16) of the "near the cell" displacement distribution.
  int unsigned         span = FullSpan;

  pdw_in_if  in_ch();
  pdw_out_if out_ch();

  periodic_displacement_wrap_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  pdw_wrap_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("periodic_displacement_wrap_top regression: fail");
    $finish;
  end

  // Result back-pressure: stall bursts of random length, started at random while idling,
  // with stretches of ready in between. Changes only at the falling edge.
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  function automatic int to_fixed(input real r, input real scale);
    int v;
    v = $rtoi(r * scale);
    if (v > CompMax) v = CompMax;
    if (v < CompMin) v = CompMin;
    return v;
  endfunction

  // x in the low 21 bits, z in the top 21
  function automatic logic [VecW-1:0] pack3(input int x, input int y, input int z);
    return {CompW'(z), CompW'(y), CompW'(x)};
  endfunction

  function automatic logic [VecW-1:0] rand_vec();
    return VecW'({$urandom, $urandom});
  endfunction

  // Each component at a corner of the Q12.8 / Q0.20 range, or near zero.
  function automatic logic [VecW-1:0] extreme_vec();
    int c [3];
    for (int j = 0; j < 3; j++) begin
      case ($urandom_range(0, 4))
        0:       c[j] = CompMax;
        1:       c[j] = CompMin;
        2:       c[j] = 0;
        3:       c[j] = 1;
        default: c[j] = -1;
      endcase
    end
    return pack3(c[0], c[1], c[2]);
  endfunction

  // Mostly displacements within a few cell lengths, where the wrap counts
  // stay small; some full-range noise and the corner values.
  function automatic delta_t rand_delta();
    delta_t d;
    case ($urandom_range(0, 9))
      0, 1: d = delta_t'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0:       d = DeltaMax;
          1:       d = DeltaMin;
          2:       d = '0;
          default: d = delta_t'(-1);
        endcase
      end
      default: d = delta_t'(longint'($urandom_range(0, 2 * span)) - longint'(span));
    endcase
    return d;
  endfunction

  // One request: optional idle burst first, then valid held until accepted.
  // Valid is left high so back-to-back requests never drop it.
  task automatic send_request(input wrap_mode_t mode, input delta_t dx, input delta_t dy,
                              input delta_t dz);
    int gap;
    gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= mode;
    in_ch.delta_x  <= dx;
    in_ch.delta_y  <= dy;
    in_ch.delta_z  <= dz;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop requests and let every result in flight come out.
  task automatic drain_pipeline();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
  endtask

  // Full register load on an idle block. The trailing write to the spare
  // index must be dropped by the block.
  task automatic load_regs(input logic [DimsW-1:0] dims,
                           input logic [VecW-1:0] ca, cb, cc, ra, rb, rc);
    drain_pipeline();
    write_reg(REG_ACTIVE_DIMS, CfgDataW'(dims));
    write_reg(REG_CELL_A, ca);
    write_reg(REG_CELL_B, cb);
    write_reg(REG_CELL_C, cc);
    write_reg(REG_RECIP_A, ra);
    write_reg(REG_RECIP_B, rb);
    write_reg(REG_RECIP_C, rc);
    write_reg(REG_UNUSED, rand_vec());
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random physical cell: a along x, b in the xy plane, sides 2..32 in
  // Q12.8. The reciprocal rows are the inverse of the upper triangular
  // cell matrix, rounded into Q0.20.
  task automatic load_triclinic(input logic [DimsW-1:0] dims, input bit ortho);
    int  ax, by, cz, bx, cx, cy;
    real rax, rby, rcz, rbx, rcx, rcy;
    ax  = $urandom_range(512, 8192);
    by  = $urandom_range(512, 8192);
    cz  = $urandom_range(512, 8192);
    bx  = ortho ? 0 : int'($urandom_range(0, ax)) - ax / 2;
    cx  = ortho ? 0 : int'($urandom_range(0, ax)) - ax / 2;
    cy  = ortho ? 0 : int'($urandom_range(0, by)) - by / 2;
    rax = ax / 256.0;
    rby = by / 256.0;
    rcz = cz / 256.0;
    rbx = bx / 256.0;
    rcx = cx / 256.0;
    rcy = cy / 256.0;
    // a few cell lengths, converted from Q12.8 to Q15.16
    span = 768 * ((ax > by) ? ((ax > cz) ? ax : cz) : ((by > cz) ? by : cz));
    load_regs(dims, pack3(ax, 0, 0), pack3(bx, by, 0), pack3(cx, cy, cz),
              pack3(to_fixed(1.0 / rax, RecipScale),
                    to_fixed(-rbx / (rax * rby), RecipScale),
                    to_fixed((rbx * rcy - rby * rcx) / (rax * rby * rcz), RecipScale)),
              pack3(0, to_fixed(1.0 / rby, RecipScale),
                    to_fixed(-rcy / (rby * rcz), RecipScale)),
              pack3(0, 0, to_fixed(1.0 / rcz, RecipScale)));
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_ACTIVE_DIMS;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = WRAP_MIN_IMAGE;
    in_ch.delta_x  = '0;
    in_ch.delta_y  = '0;
    in_ch.delta_z  = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- Directed ---
    // Reset settings: three dims active but every vector zero, so each
    // reciprocal is zero and the displacement must come back untouched.
    send_request(WRAP_MIN_IMAGE, '0, '0, '0);
    send_request(WRAP_MIN_IMAGE, DeltaMax, DeltaMax, DeltaMax);
    send_request(WRAP_BOX, DeltaMin, DeltaMin, DeltaMin);
    send_request(WRAP_BOX, DeltaMax, DeltaMin, NegHalf);

    // 8.0 cube: ties at exactly one half round up in minimum-image mode,
    // box mode floors (negative offsets move up a whole cell).
    load_regs(2'd3, pack3(CellEight, 0, 0), pack3(0, CellEight, 0), pack3(0, 0, CellEight),
              pack3(RecipEighth, 0, 0), pack3(0, RecipEighth, 0), pack3(0, 0, RecipEighth));
    send_request(WRAP_MIN_IMAGE, PosFour, '0, '0);
    send_request(WRAP_MIN_IMAGE, NegFour, '0, '0);
    send_request(WRAP_BOX, PosFour, '0, '0);
    send_request(WRAP_BOX, NegHalf, NegHalf, NegHalf);
    send_request(WRAP_MIN_IMAGE, '0, PosFour, NegFour);
    send_request(WRAP_MIN_IMAGE, Hundred, -Hundred, Hundred);
    send_request(WRAP_BOX, Hundred, -Hundred, Hundred);
    send_request(WRAP_MIN_IMAGE, DeltaMax, DeltaMin, DeltaMax);
    send_request(WRAP_BOX, DeltaMin, DeltaMax, DeltaMin);

    // Wrapping disabled with a real cell loaded: pass-through.
    load_regs(2'd0, pack3(CellEight, 0, 0), pack3(0, CellEight, 0), pack3(0, 0, CellEight),
              pack3(RecipEighth, 0, 0), pack3(0, RecipEighth, 0), pack3(0, 0, RecipEighth));
    send_request(WRAP_MIN_IMAGE, PosFour, '0, '0);
    send_request(WRAP_BOX, DeltaMax, DeltaMin, NegHalf);

    // Inconsistent vectors at the range corners: the step overshoots the 32-bit
    // range and every component must saturate, but in the last request the offsets cancel and pass through.
    load_regs(2'd1, pack3(CompMin, CompMin, CompMin), rand_vec(), rand_vec(),
              pack3(CompMax, CompMax, CompMax), rand_vec(), rand_vec());
    send_request(WRAP_MIN_IMAGE, DeltaMax, DeltaMax, DeltaMax);
    send_request(WRAP_BOX, DeltaMin, DeltaMin, DeltaMin);
    send_request(WRAP_MIN_IMAGE, DeltaMax, DeltaMin, '0);

    // --- Random phases, 100 requests each ---
    // Physical cells for most phases; raw register noise and corner vectors
    // to hit saturation; one phase with wrapping off. Last phase runs flat out.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: load_triclinic(2'd3, 1'b0);
        1: load_triclinic(2'd1, 1'b1);
        2: begin
          span = FullSpan;
          load_regs(2'd3, rand_vec(), rand_vec(), rand_vec(),
                    rand_vec(), rand_vec(), rand_vec());
        end
        3: load_triclinic(2'd2, 1'b0);
        4: begin
          span = FullSpan;
          load_regs(2'd3, extreme_vec(), extreme_vec(), extreme_vec(),
                    extreme_vec(), extreme_vec(), extreme_vec());
        end
        5: begin
          span = FullSpan;
          load_regs(2'd0, rand_vec(), rand_vec(), rand_vec(),
                    rand_vec(), rand_vec(), rand_vec());
        end
        default: begin
          idling = 1'b0;
          load_triclinic(2'd3, 1'b0);
        end
      endcase
      repeat (100) begin
        send_request(wrap_mode_t'($urandom_range(0, 1)), rand_delta(), rand_delta(),
                     rand_delta());
      end
    end

    // Everything out, then a further idle wait to catch strays.
    drain_pipeline();
    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("periodic_displacement_wrap_top regression: pass");
    end else begin
      $display("periodic_displacement_wrap_top regression: fail");
    end
    $finish;
  end

endmodule
